[design/orav_pkg.sv]
package orav_pkg;

  // Fixed port widths of the block
  localparam int unsigned IN_SAMPLE_W  = 16;
  localparam int unsigned AVERAGE_W    = 16;
  localparam int unsigned HELD_COUNT_W = 4;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

endpackage

[design/orav_ram.sv]
module orav_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/orav_front.sv]
module orav_front
  import orav_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned IW          = $clog2(DEPTH),
  parameter int unsigned SUMW        = SAMPLE_BITS + $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [IN_SAMPLE_W-1:0] in_sample,
  output logic                   rec_valid,
  input  logic                   rec_ready,
  output logic [SUMW-1:0]        rec_sum,
  output logic [IW-1:0]          rec_held,
  output logic                   rec_full
);

  front_state_t state_r, state_nxt;
  logic [IW-1:0]          head_r, head_nxt;
  logic [IW-1:0]          tail_r, tail_nxt;
  logic [IW-1:0]          count_r, count_nxt;
  logic [SUMW-1:0]        sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [SAMPLE_BITS-1:0] oldest;
  logic [SUMW-1:0]        drop;
  logic                   full_before;
  logic                   accept;

  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
    ring_next = (idx == LAST) ? '0 : idx + 1'b1;
  endfunction

  assign in_ready    = (state_r == F_IDLE);
  assign accept      = in_valid && in_ready;
  assign sample_nxt  = SAMPLE_BITS'(in_sample);
  assign full_before = (count_r == LAST);
  assign drop        = full_before ? SUMW'(oldest) : '0;

  // Read the tail slot on accept; when the ring is full the head slot written is not the tail.
  orav_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (head_r),
    .wdata (sample_nxt),
    .raddr (tail_r),
    .rdata (oldest)
  );

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          head_nxt  = ring_next(head_r);
          state_nxt = F_CALC;
        end
      end
      F_CALC: begin
        sum_nxt = sum_r + SUMW'(sample_r) - drop;
        if (full_before) begin
          tail_nxt = ring_next(tail_r);
        end else begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (rec_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample_nxt;
    end
  end

  assign rec_valid = (state_r == F_PUSH);
  assign rec_sum   = sum_r;
  assign rec_held  = count_r;
  assign rec_full  = (count_r == LAST);

endmodule

[design/orav_queue.sv]
module orav_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/orav_back.sv]
module orav_back
  import orav_pkg::*;
#(
  parameter int unsigned IW   = 4,
  parameter int unsigned SUMW = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rec_valid,
  output logic                    rec_ready,
  input  logic [SUMW-1:0]         rec_sum,
  input  logic [IW-1:0]           rec_held,
  input  logic                    rec_full,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [AVERAGE_W-1:0]    out_average,
  output logic [HELD_COUNT_W-1:0] out_held_count,
  output logic                    out_is_full
);

  localparam int unsigned KW = $clog2(SUMW);

  back_state_t state_r, state_nxt;
  logic [SUMW-1:0] dvd_r, dvd_nxt;
  logic [IW-1:0]   dvs_r, dvs_nxt;
  logic [IW-1:0]   rem_r, rem_nxt;
  logic [KW-1:0]   step_r, step_nxt;
  logic            full_r, full_nxt;
  logic [IW:0]     trial;
  logic            qbit;
  logic            pop;
  logic            load_out;
  logic            out_valid_r, out_valid_nxt;
  logic [AVERAGE_W-1:0]    avg_r;
  logic [HELD_COUNT_W-1:0] held_r;
  logic                    is_full_r;

  assign rec_ready = (state_r == B_IDLE);
  assign pop       = rec_valid && rec_ready;
  assign load_out  = (state_r == B_DONE) && (!out_valid_r || out_ready);

  // One restoring step: the quotient bit shifts in where the dividend bit left.
  assign trial = {rem_r, dvd_r[SUMW-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    full_nxt  = full_r;
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          dvd_nxt   = rec_sum;
          dvs_nxt   = rec_held;
          full_nxt  = rec_full;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        rem_nxt  = qbit ? IW'(trial - {1'b0, dvs_r}) : IW'(trial);
        dvd_nxt  = {dvd_r[SUMW-2:0], qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == KW'(SUMW - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    full_r <= full_nxt;
    if (load_out) begin
      avg_r     <= AVERAGE_W'(dvd_r);
      held_r    <= HELD_COUNT_W'(dvs_r);
      is_full_r <= full_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_average    = avg_r;
  assign out_held_count = held_r;
  assign out_is_full    = is_full_r;

endmodule

[design/overwriting_ring_average_top.sv]
// Path: an accepted sample's running sum is updated in F_CALC and offered in F_PUSH;
// the record passes the two-entry queue; the back divides it in B_RUN and registers
// the result from B_DONE. The bit-serial divider retires one quotient bit per cycle;
// the front can take a new sample while the divider works on an earlier record.
// Reset: synchronous, active low; clears pointers, fill count, running sum and all
// handshake state. The sample store is not cleared and needs no clearing pass.
module overwriting_ring_average_top
  import orav_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [IN_SAMPLE_W-1:0]  in_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [AVERAGE_W-1:0]    out_average,
  output logic [HELD_COUNT_W-1:0] out_held_count,
  output logic                    out_is_full
);

  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned SUMW = SAMPLE_BITS + IW;
  localparam int unsigned RECW = SUMW + IW + 1;

  logic            f_valid, f_ready;
  logic [SUMW-1:0] f_sum;
  logic [IW-1:0]   f_held;
  logic            f_full;
  logic            b_valid, b_ready;
  logic [RECW-1:0] b_data;
  logic [SUMW-1:0] b_sum;
  logic [IW-1:0]   b_held;
  logic            b_full;

  orav_front #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IW          (IW),
    .SUMW        (SUMW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec_sum   (f_sum),
    .rec_held  (f_held),
    .rec_full  (f_full)
  );

  orav_queue #(.WIDTH(RECW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_sum, f_held, f_full}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  assign {b_sum, b_held, b_full} = b_data;

  orav_back #(
    .IW   (IW),
    .SUMW (SUMW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rec_valid      (b_valid),
    .rec_ready      (b_ready),
    .rec_sum        (b_sum),
    .rec_held       (b_held),
    .rec_full       (b_full),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_held_count (out_held_count),
    .out_is_full    (out_is_full)
  );

`ifndef SYNTHESIS
  a_rec_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid |-> f_held != '0)
    else $error("request leaves the front with no held samples");

  a_rec_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid && b_full |-> b_held == IW'(DEPTH - 1))
    else $error("full flag disagrees with held count");

  a_out_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_held_count != '0)
    else $error("result with zero held count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front took a second request while computing");
`endif

endmodule
